[rtl/core/triangle_face_normal_defines.svh]
// ----------------------------------------------------------------------------
// triangle_face_normal_defines.svh
// Assertion macros shared by the triangle face normal RTL.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset
`define TFN_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("triangle_face_normal: assertion failed");
// Check that a condition implies another one in the same cycle
`define TFN_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("triangle_face_normal: implication failed");
`else
`define TFN_ASSERT(lbl, clk, rst, prop)
`define TFN_ASSERT_IMP(lbl, clk, rst, pre, post)
`endif

`endif

[rtl/core/tfn_pkg.sv]
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared constants and pipeline control type for the face normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tfn_pkg;

  // Default coordinate width and fraction bits of the normal
  localparam int COORD_WIDTH_DEF      = 16;
  localparam int NORMAL_FRAC_BITS_DEF = 14;

  // Control that travels with each beat down the pipeline
  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tfn_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/tfn_cross.sv]
// ----------------------------------------------------------------------------
// tfn_cross
// Three stages: edge vectors, partial products, cross product magnitude/sign.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_cross #(
  parameter int COORD_WIDTH = tfn_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] ax,
  input  wire logic signed [COORD_WIDTH-1:0] ay,
  input  wire logic signed [COORD_WIDTH-1:0] az,
  input  wire logic signed [COORD_WIDTH-1:0] bx,
  input  wire logic signed [COORD_WIDTH-1:0] by,
  input  wire logic signed [COORD_WIDTH-1:0] bz,
  input  wire logic signed [COORD_WIDTH-1:0] cx,
  input  wire logic signed [COORD_WIDTH-1:0] cy,
  input  wire logic signed [COORD_WIDTH-1:0] cz,
  output tfn_pkg::tfn_ctrl_t                 ctrl_out,
  output logic [2:0][2*COORD_WIDTH+1:0]      mag_out
);

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int NW = PW + 1;

  logic                 v1, v2, v3;
  logic                 degen3;
  logic [2:0]           neg3;
  logic signed [EW-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [PW-1:0] p_uyvz, p_uzvy, p_uzvx, p_uxvz, p_uxvy, p_uyvx;
  logic signed [NW-1:0] n0, n1, n2;

  // Form the edge vectors from the first corner
  always_ff @(posedge clk) begin
    ux <= {bx[COORD_WIDTH-1], bx} - {ax[COORD_WIDTH-1], ax};
    uy <= {by[COORD_WIDTH-1], by} - {ay[COORD_WIDTH-1], ay};
    uz <= {bz[COORD_WIDTH-1], bz} - {az[COORD_WIDTH-1], az};
    vx <= {cx[COORD_WIDTH-1], cx} - {ax[COORD_WIDTH-1], ax};
    vy <= {cy[COORD_WIDTH-1], cy} - {ay[COORD_WIDTH-1], ay};
    vz <= {cz[COORD_WIDTH-1], cz} - {az[COORD_WIDTH-1], az};
  end

  // Multiply edge components pairwise
  always_ff @(posedge clk) begin
    p_uyvz <= uy * vz;
    p_uzvy <= uz * vy;
    p_uzvx <= uz * vx;
    p_uxvz <= ux * vz;
    p_uxvy <= ux * vy;
    p_uyvx <= uy * vx;
  end

  // Subtract into the cross product components
  always_comb begin
    n0 = p_uyvz - p_uzvy;
    n1 = p_uzvx - p_uxvz;
    n2 = p_uxvy - p_uyvx;
  end

  // Split components into magnitude and sign
  always_ff @(posedge clk) begin
    mag_out[0] <= PW'(n0[NW-1] ? -n0 : n0);
    mag_out[1] <= PW'(n1[NW-1] ? -n1 : n1);
    mag_out[2] <= PW'(n2[NW-1] ? -n2 : n2);
    neg3       <= {n2[NW-1], n1[NW-1], n0[NW-1]};
    degen3     <= (n0 == '0) && (n1 == '0) && (n2 == '0);
  end

  // Advance the valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Bundle the control beat
  assign ctrl_out = '{valid: v3, degen: degen3, neg: neg3};

endmodule

`default_nettype wire

[rtl/core/tfn_square.sv]
// ----------------------------------------------------------------------------
// tfn_square
// Three stages: split squares, square assembly, squared length and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_square #(
  parameter int MW = 2 * tfn_pkg::COORD_WIDTH_DEF + 2,
  parameter int F  = tfn_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int DW = 2 * MW + 2 + 2 * F + 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire tfn_pkg::tfn_ctrl_t     ctrl_in,
  input  wire logic [2:0][MW-1:0]     mag_in,
  output tfn_pkg::tfn_ctrl_t          ctrl_out,
  output logic [DW-1:0]               s_out,
  output logic [2:0][DW-1:0]          r_out
);

  localparam int HW = (MW + 1) / 2;
  localparam int LW = MW - HW;
  localparam int SQW = 2 * MW;

  tfn_pkg::tfn_ctrl_t       c1, c2;
  logic [2:0][2*LW-1:0]     p_hh;
  logic [2:0][LW+HW-1:0]    p_hl;
  logic [2:0][2*HW-1:0]     p_ll;
  logic [2:0][SQW-1:0]      sq;

  // Square each magnitude as three half-width products
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_hh[i] <= mag_in[i][MW-1:HW] * mag_in[i][MW-1:HW];
      p_hl[i] <= mag_in[i][MW-1:HW] * mag_in[i][HW-1:0];
      p_ll[i] <= mag_in[i][HW-1:0] * mag_in[i][HW-1:0];
    end
  end

  // Assemble the full squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= (SQW'(p_hh[i]) << (2 * HW)) + (SQW'(p_hl[i]) << (HW + 1)) + SQW'(p_ll[i]);
    end
  end

  // Sum the squared length; scale each square as the starting remainder
  always_ff @(posedge clk) begin
    s_out <= DW'(sq[0]) + DW'(sq[1]) + DW'(sq[2]);
    for (int i = 0; i < 3; i++) begin
      r_out[i] <= DW'(sq[i]) << (2 * F);
    end
  end

  // Advance the control beat
  always_ff @(posedge clk) begin
    if (rst) begin
      c1       <= '0;
      c2       <= '0;
      ctrl_out <= '0;
    end else begin
      c1       <= ctrl_in;
      c2       <= c1;
      ctrl_out <= c2;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tfn_root_stage.sv]
// ----------------------------------------------------------------------------
// tfn_root_stage
// One bit of the scaled inverse square root quotient, for all three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tfn_root_stage #(
  parameter int F  = tfn_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int DW = 4 * tfn_pkg::COORD_WIDTH_DEF + 9 + 2 * F,
  parameter int K  = 0
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tfn_pkg::tfn_ctrl_t ctrl_in,
  input  wire logic [DW-1:0]      s_in,
  input  wire logic [2:0][DW-1:0] r_in,
  input  wire logic [2:0][DW-1:0] t_in,
  input  wire logic [2:0][F:0]    q_in,
  output tfn_pkg::tfn_ctrl_t      ctrl_out,
  output logic [DW-1:0]           s_out,
  output logic [2:0][DW-1:0]      r_out,
  output logic [2:0][DW-1:0]      t_out,
  output logic [2:0][F:0]         q_out
);

  logic [2:0][DW-1:0] delta;
  logic [2:0]         fit;

  // Cost of setting this bit: (2*q*2^K + 2^2K) * S, built from q*S by shifts
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      delta[i] = (t_in[i] << (K + 1)) + (s_in << (2 * K));
      fit[i]   = delta[i] <= r_in[i];
    end
  end

  // Take the bit where the remainder covers it
  always_ff @(posedge clk) begin
    s_out <= s_in;
    for (int i = 0; i < 3; i++) begin
      if (fit[i]) begin
        r_out[i] <= r_in[i] - delta[i];
        t_out[i] <= t_in[i] + (s_in << K);
        q_out[i] <= q_in[i] | ((F+1)'(1) << K);
      end else begin
        r_out[i] <= r_in[i];
        t_out[i] <= t_in[i];
        q_out[i] <= q_in[i];
      end
    end
  end

  // Advance the control beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
  end

endmodule

`default_nettype wire

[rtl/core/triangle_face_normal.sv]
// ----------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle from its three corners, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the nine corner coordinates and raise start; a beat is taken at
//   each clock edge with start high and busy low. busy is high only during
//   reset, so one triangle can be taken every cycle.
//   Each result appears on normal_x/y/z and degenerate for one cycle with
//   done high, in order, one result per triangle. Throughput is one
//   triangle per cycle: three stages form the cross product, three more
//   its squared length, then one stage per quotient bit
//   (NORMAL_FRAC_BITS + 1 of them) and one output register.
//   Components are signed with NORMAL_FRAC_BITS fraction bits, rounded
//   toward zero. A zero cross product gives a zero vector and degenerate.
//   Reset drops every beat in flight; done stays low until new results.
//   The receiver cannot stall: results must be taken when done is high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_face_normal_defines.svh"

module triangle_face_normal #(
  parameter int COORD_WIDTH      = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_WIDTH-1:0]       ax,
  input  wire logic signed [COORD_WIDTH-1:0]       ay,
  input  wire logic signed [COORD_WIDTH-1:0]       az,
  input  wire logic signed [COORD_WIDTH-1:0]       bx,
  input  wire logic signed [COORD_WIDTH-1:0]       by,
  input  wire logic signed [COORD_WIDTH-1:0]       bz,
  input  wire logic signed [COORD_WIDTH-1:0]       cx,
  input  wire logic signed [COORD_WIDTH-1:0]       cy,
  input  wire logic signed [COORD_WIDTH-1:0]       cz,
  output logic                                     done,
  output logic signed [NORMAL_FRAC_BITS+1:0]       normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0]       normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0]       normal_z,
  output logic                                     degenerate
);

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int MW  = 2 * COORD_WIDTH + 2;
  localparam int SW  = 2 * MW + 2;
  localparam int DW  = SW + 2 * F + 3;
  localparam int NRW = F + 2;
  localparam int LAT = F + 8;

  tfn_pkg::tfn_ctrl_t   cross_ctrl;
  logic [2:0][MW-1:0]   cross_mag;

  tfn_pkg::tfn_ctrl_t   ctrl_pipe [0:F+1];
  logic [DW-1:0]        s_pipe    [0:F+1];
  logic [2:0][DW-1:0]   r_pipe    [0:F+1];
  logic [2:0][DW-1:0]   t_pipe    [0:F+1];
  logic [2:0][F:0]      q_pipe    [0:F+1];

  logic [2:0][NRW-1:0]  nrm;

  // Hold off beats only while in reset
  assign busy = rst;

  tfn_cross #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .ax       (ax),
    .ay       (ay),
    .az       (az),
    .bx       (bx),
    .by       (by),
    .bz       (bz),
    .cx       (cx),
    .cy       (cy),
    .cz       (cz),
    .ctrl_out (cross_ctrl),
    .mag_out  (cross_mag)
  );

  tfn_square #(
    .MW (MW),
    .F  (F),
    .DW (DW)
  ) u_square (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (cross_ctrl),
    .mag_in   (cross_mag),
    .ctrl_out (ctrl_pipe[0]),
    .s_out    (s_pipe[0]),
    .r_out    (r_pipe[0])
  );

  // Start each lane with an empty quotient
  assign t_pipe[0] = '0;
  assign q_pipe[0] = '0;

  // One stage per quotient bit, most significant first
  for (genvar g = 0; g <= F; g++) begin : g_root
    tfn_root_stage #(
      .F  (F),
      .DW (DW),
      .K  (F - g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .ctrl_in  (ctrl_pipe[g]),
      .s_in     (s_pipe[g]),
      .r_in     (r_pipe[g]),
      .t_in     (t_pipe[g]),
      .q_in     (q_pipe[g]),
      .ctrl_out (ctrl_pipe[g+1]),
      .s_out    (s_pipe[g+1]),
      .r_out    (r_pipe[g+1]),
      .t_out    (t_pipe[g+1]),
      .q_out    (q_pipe[g+1])
    );
  end

  // Apply signs and drop degenerate results to zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ctrl_pipe[F+1].degen) begin
        nrm[i] = '0;
      end else if (ctrl_pipe[F+1].neg[i]) begin
        nrm[i] = -{1'b0, q_pipe[F+1][i]};
      end else begin
        nrm[i] = {1'b0, q_pipe[F+1][i]};
      end
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    normal_x   <= nrm[0];
    normal_y   <= nrm[1];
    normal_z   <= nrm[2];
    degenerate <= ctrl_pipe[F+1].degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_pipe[F+1].valid;
    end
  end

  // A result beat follows a taken beat by the fixed latency
  `TFN_ASSERT_IMP(a_latency, clk, rst, done, $past(start && !busy, LAT))
  // A degenerate result carries a zero vector
  `TFN_ASSERT_IMP(a_degen_zero, clk, rst, done && degenerate,
                  normal_x == '0 && normal_y == '0 && normal_z == '0)
  // A proper triangle never yields an all-zero normal
  `TFN_ASSERT_IMP(a_nonzero, clk, rst, done && !degenerate,
                  normal_x != '0 || normal_y != '0 || normal_z != '0)

endmodule

`default_nettype wire

[sim/triangle_face_normal_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_tb
// Streams triangles into the face normal pipeline and checks every normal.
// Each accepted beat feeds an exact integer predictor (cross product, squared
// length, bisection on the quotient). Its output is queued, and each done
// cycle is compared field by field against the oldest queued normal.
// ----------------------------------------------------------------------------

module triangle_face_normal_tb;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [15:0] comp_t;

  typedef struct {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degen;
  } normal_t;

  localparam int FRAC       = 14;
  localparam int WDOG_LIMIT = 2000;
  localparam int DRAIN      = 40;

  // Queue of predicted normals, oldest first
  class normal_scoreboard;
    normal_t pending[$];
    int      errors;

    function new();
      pending = {};
      errors  = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    // Largest q in [0, 2^FRAC] with q^2 * sum <= (mag * 2^FRAC)^2
    function longint unsigned unit_part(longint unsigned mag, logic [127:0] sum);
      logic [127:0] lim;
      logic [127:0] mid;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned m;
      lim = ({64'd0, mag} << FRAC);
      lim = lim * lim;
      lo  = 0;
      hi  = 1 << FRAC;
      while (lo < hi) begin
        m   = lo + (hi - lo + 1) / 2;
        mid = m * m;
        if (mid * sum <= lim) lo = m;
        else hi = m - 1;
      end
      return lo;
    endfunction

    // Predict the normal of one accepted triangle
    function void note_triangle(coord_t p[9]);
      longint ux, uy, uz, vx, vy, vz;
      longint n[3];
      longint unsigned mag[3];
      logic [127:0] sum;
      longint unsigned q;
      comp_t r[3];
      normal_t e;
      ux = longint'(p[3]) - longint'(p[0]);
      uy = longint'(p[4]) - longint'(p[1]);
      uz = longint'(p[5]) - longint'(p[2]);
      vx = longint'(p[6]) - longint'(p[0]);
      vy = longint'(p[7]) - longint'(p[1]);
      vz = longint'(p[8]) - longint'(p[2]);
      n[0] = uy * vz - uz * vy;
      n[1] = uz * vx - ux * vz;
      n[2] = ux * vy - uy * vx;
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
        e = '{nx: 0, ny: 0, nz: 0, degen: 1'b1};
      end else begin
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
          sum = sum + {64'd0, mag[i]} * {64'd0, mag[i]};
        end
        for (int i = 0; i < 3; i++) begin
          q = unit_part(mag[i], sum);
          r[i] = (n[i] < 0) ? comp_t'(-longint'(q)) : comp_t'(q);
        end
        e = '{nx: r[0], ny: r[1], nz: r[2], degen: 1'b0};
      end
      pending.insert(pending.size(), e);
    endfunction

    // Compare one result with the oldest prediction
    task check_normal(normal_t got);
      normal_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d %0d %0d deg=%0b",
                         got.nx, got.ny, got.nz, got.degen));
      end else begin
        e = pending.pop_front();
        if (got.nx !== e.nx)
          report($sformatf("normal_x got %0d exp %0d", got.nx, e.nx));
        if (got.ny !== e.ny)
          report($sformatf("normal_y got %0d exp %0d", got.ny, e.ny));
        if (got.nz !== e.nz)
          report($sformatf("normal_z got %0d exp %0d", got.nz, e.nz));
        if (got.degen !== e.degen)
          report($sformatf("degenerate got %0b exp %0b", got.degen, e.degen));
      end
    endtask
  endclass

  logic   clk;
  logic   rst;
  logic   start;
  logic   busy;
  logic   done;
  coord_t pt[9];
  comp_t  normal_x;
  comp_t  normal_y;
  comp_t  normal_z;
  logic   degenerate;

  normal_scoreboard sb;
  int idle_pct;
  int quiet_cycles;

  triangle_face_normal dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .ax         (pt[0]),
    .ay         (pt[1]),
    .az         (pt[2]),
    .bx         (pt[3]),
    .by         (pt[4]),
    .bz         (pt[5]),
    .cx         (pt[6]),
    .cy         (pt[7]),
    .cz         (pt[8]),
    .done       (done),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .degenerate (degenerate)
  );

  // Generate a 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Observe accepted beats and results
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_triangle(pt);
      if (done) sb.check_normal('{nx: normal_x, ny: normal_y, nz: normal_z,
                                  degen: degenerate});
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Send one triangle, idling first as the current phase asks
  task send_triangle(coord_t p[9]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 9; i++) pt[i] <= p[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Build a random triangle of one of several shapes
  function void make_triangle(output coord_t p[9]);
    int kind;
    int k;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) p[i] = coord_t'($urandom);
    case (kind)
      0, 1: begin
        // small triangle around a random anchor
        for (int i = 3; i < 9; i++) p[i] = p[i % 3] + coord_t'($urandom_range(64) - 32);
      end
      2: begin
        // collinear corners: C = A + k * (B - A)
        k = $urandom_range(6) - 3;
        for (int i = 0; i < 3; i++) begin
          p[i]     = coord_t'($urandom_range(2000) - 1000);
          p[i + 3] = p[i] + coord_t'($urandom_range(400) - 200);
          p[i + 6] = p[i] + coord_t'(k * (p[i + 3] - p[i]));
        end
      end
      3: begin
        // coincident corners
        k = $urandom_range(2);
        for (int i = 0; i < 3; i++) p[3 * k + i] = p[3 * ((k + 1) % 3) + i];
      end
      4: begin
        // triangle in an axis plane
        k = $urandom_range(2);
        p[k + 3] = p[k];
        p[k + 6] = p[k];
      end
      5: begin
        // corners at the extremes
        for (int i = 0; i < 9; i++) p[i] = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      default: ;
    endcase
  endfunction

  // Directed triangles
  task run_directed();
    coord_t p[9];
    coord_t ext[4];
    ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    p = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                     send_triangle(p);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                     send_triangle(p);
    p = '{0, 0, 0, 0, 1, 0, 1, 0, 0};                     send_triangle(p);
    p = '{0, 0, 0, 0, 0, 1, 1, 0, 0};                     send_triangle(p);
    p = '{0, 0, 0, 0, 1, 0, 0, 0, 1};                     send_triangle(p);
    p = '{0, 0, 0, 1, 1, 1, 2, 2, 2};                     send_triangle(p);
    p = '{5, 5, 5, 5, 5, 5, 9, -3, 7};                    send_triangle(p);
    p = '{1, 2, 3, 1, 2, 3, 1, 2, 3};                     send_triangle(p);
    p = '{0, 0, 0, 1, 0, 0, 1, 1, 1};                     send_triangle(p);
    p = '{0, 0, 0, 3, 0, 0, 0, 4, 0};                     send_triangle(p);
    p = '{-32768, -32768, -32768, 32767, -32768, -32768,
          -32768, 32767, -32768};                         send_triangle(p);
    p = '{32767, 32767, 32767, -32768, 32767, 32767,
          32767, -32768, 32767};                          send_triangle(p);
    p = '{-32768, -32768, -32768, 32767, 32767, -32768,
          -32768, 32767, 32767};                          send_triangle(p);
    p = '{32767, -32768, 32767, -32768, 32767, -32768,
          32767, 32767, -32768};                          send_triangle(p);
    p = '{-32768, -32768, -32768, 32767, 32767, 32767,
          -32768, -32768, -32768};                        send_triangle(p);
    p = '{-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768};
    send_triangle(p);
    for (int j = 0; j < 6; j++) begin
      for (int i = 0; i < 9; i++) p[i] = ext[$urandom_range(3)];
      send_triangle(p);
    end
  endtask

  initial begin
    coord_t p[9];
    sb       = new();
    rst      = 1'b1;
    start    = 1'b0;
    idle_pct = 0;
    quiet_cycles = 0;
    for (int i = 0; i < 9; i++) pt[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 71 : 0;
      for (int n = 0; n < 610; n++) begin
        make_triangle(p);
        send_triangle(p);
      end
    end
    start <= 1'b0;

    // Drain the pipeline, then allow stragglers to show up
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[triangle_face_normal.f]
+incdir+rtl/core
rtl/core/tfn_pkg.sv
rtl/core/tfn_cross.sv
rtl/core/tfn_square.sv
rtl/core/tfn_root_stage.sv
rtl/core/triangle_face_normal.sv
sim/triangle_face_normal_tb.sv
